// ===== rtl/dpq_pkg.sv =====
// Package for the double-ended priority queue: operation codes and control types.
package dpq_pkg;

  // Operation codes of one input item
  typedef enum logic [1:0] {
    OP_INSERT     = 2'd0,
    OP_REMOVE_MAX = 2'd1,
    OP_REMOVE_MIN = 2'd2,
    OP_CLEAR      = 2'd3
  } dpq_op_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // latch op and value, start position at count
    logic set_ovf;   // insert dropped
    logic rd_prev;   // read entry at position - 1
    logic wr_shift;  // move read entry up one place, position - 1
    logic wr_key;    // write new value at position, count + 1
    logic rm_max;    // drop last entry
    logic rm_min;    // drop first entry
    logic clr;       // empty the store
    logic rd_min;    // read first entry
    logic rd_max;    // read last entry
    logic cap_min;   // capture read data as minimum
    logic cap_max;   // capture read data as maximum
    logic emit;      // load result register
  } dpq_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    dpq_op_t op;
    logic    full;
    logic    empty;
    logic    pos_zero;
    logic    greater;   // read entry greater than the new value
    logic    out_free;  // result register can take an item
  } dpq_stat_t;

endpackage

// ===== rtl/dpq_datapath.sv =====
// Datapath: sorted circular store, count, position and result registers.
module dpq_datapath
  import dpq_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dpq_cmd_t           cmd,
  output dpq_stat_t          stat,
  input  logic [1:0]         in_operation,
  input  logic signed [31:0] in_value,
  input  logic               out_stall,
  output logic               out_valid,
  output logic               out_is_empty,
  output logic signed [31:0] out_min_value,
  output logic signed [31:0] out_max_value,
  output logic [10:0]        out_entry_count,
  output logic               out_overflow
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int DEPTH = 2 ** AW;
  localparam int CW    = $clog2(CAPACITY + 1);

  logic signed [31:0] mem [DEPTH];

  dpq_op_t            op_r;
  logic signed [31:0] key_r;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      pos_r, pos_nxt;
  logic [AW-1:0]      base_r, base_nxt;
  logic signed [31:0] rdata_r;
  logic signed [31:0] min_r, max_r;
  logic               ovf_r;
  logic               out_valid_r;
  logic               out_empty_r;
  logic signed [31:0] out_min_r, out_max_r;
  logic [10:0]        out_cnt_r;
  logic               out_ovf_r;

  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic               wr_en;
  logic signed [31:0] wr_data;
  logic [CW+10:0]     cnt_ext;

  // Addresses relative to the first entry; the store wraps at DEPTH
  always_comb begin
    rd_addr = base_r;
    if (cmd.rd_prev) begin
      rd_addr = base_r + pos_r[AW-1:0] - AW'(1);
    end else if (cmd.rd_max) begin
      rd_addr = base_r + cnt_r[AW-1:0] - AW'(1);
    end
    wr_addr = base_r + pos_r[AW-1:0];
    wr_en   = cmd.wr_shift | cmd.wr_key;
    wr_data = cmd.wr_key ? key_r : rdata_r;
  end

  // Store with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_prev | cmd.rd_min | cmd.rd_max) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Count, first-entry pointer and insert position
  always_comb begin
    cnt_nxt  = cnt_r;
    base_nxt = base_r;
    pos_nxt  = pos_r;
    if (cmd.load) begin
      pos_nxt = cnt_r;
    end
    if (cmd.wr_shift) begin
      pos_nxt = pos_r - CW'(1);
    end
    if (cmd.wr_key) begin
      cnt_nxt = cnt_r + CW'(1);
    end
    if (cmd.rm_max) begin
      cnt_nxt = cnt_r - CW'(1);
    end
    if (cmd.rm_min) begin
      cnt_nxt  = cnt_r - CW'(1);
      base_nxt = base_r + AW'(1);
    end
    if (cmd.clr) begin
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      base_r <= base_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign cnt_ext = {11'd0, cnt_r};

  // Item payload and result registers
  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    if (cmd.load) begin
      op_r  <= dpq_op_t'(in_operation);
      key_r <= in_value;
      ovf_r <= 1'b0;
    end
    if (cmd.set_ovf) begin
      ovf_r <= 1'b1;
    end
    if (cmd.cap_min) begin
      min_r <= rdata_r;
    end
    if (cmd.cap_max) begin
      max_r <= rdata_r;
    end
    if (cmd.emit) begin
      out_empty_r <= (cnt_r == '0);
      out_min_r   <= (cnt_r == '0) ? 32'sd0 : min_r;
      out_max_r   <= (cnt_r == '0) ? 32'sd0 : max_r;
      out_cnt_r   <= cnt_ext[10:0];
      out_ovf_r   <= ovf_r;
    end
  end

  always_comb begin
    stat.op       = op_r;
    stat.full     = (cnt_r == CW'(CAPACITY));
    stat.empty    = (cnt_r == '0);
    stat.pos_zero = (pos_r == '0);
    stat.greater  = (rdata_r > key_r);
    stat.out_free = !out_valid_r || !out_stall;
  end

  assign out_valid       = out_valid_r;
  assign out_is_empty    = out_empty_r;
  assign out_min_value   = out_min_r;
  assign out_max_value   = out_max_r;
  assign out_entry_count = out_cnt_r;
  assign out_overflow    = out_ovf_r;

endmodule

// ===== rtl/dpq_ctrl.sv =====
// Controller: sequences one item's operation, insert shifting and result reads.
module dpq_ctrl
  import dpq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  dpq_stat_t stat,
  output dpq_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_INS_CHK, S_INS_CMP, S_RD_MIN, S_RD_MAX, S_CAPT, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_RD_MIN;
        unique case (stat.op)
          OP_INSERT: begin
            if (stat.full) begin
              cmd.set_ovf = 1'b1;
            end else begin
              state_nxt = S_INS_CHK;
            end
          end
          OP_REMOVE_MAX: cmd.rm_max = !stat.empty;
          OP_REMOVE_MIN: cmd.rm_min = !stat.empty;
          OP_CLEAR:      cmd.clr    = 1'b1;
          default:       cmd.clr    = 1'b1;
        endcase
      end
      // Walk down from the tail until the slot for the new value is found
      S_INS_CHK: begin
        if (stat.pos_zero) begin
          cmd.wr_key = 1'b1;
          state_nxt  = S_RD_MIN;
        end else begin
          cmd.rd_prev = 1'b1;
          state_nxt   = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (stat.greater) begin
          cmd.wr_shift = 1'b1;
          state_nxt    = S_INS_CHK;
        end else begin
          cmd.wr_key = 1'b1;
          state_nxt  = S_RD_MIN;
        end
      end
      S_RD_MIN: begin
        cmd.rd_min = 1'b1;
        state_nxt  = S_RD_MAX;
      end
      S_RD_MAX: begin
        cmd.cap_min = 1'b1;
        cmd.rd_max  = 1'b1;
        state_nxt   = S_CAPT;
      end
      S_CAPT: begin
        cmd.cap_max = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// ===== rtl/double_ended_priority_queue_core.sv =====
// Removals, clears and dropped inserts go from accept through decode to the min and max reads;
// an insert first steps down once per entry larger than the new value (one store read, one
// store write), then places it, with no read when it lands at the front.
// Items are handled one at a time; the next item is taken while a result waits.
// Reset (rst_n, synchronous) empties the queue at once; the store needs no clearing.
// Top level: double-ended priority queue core.
module double_ended_priority_queue_core
  import dpq_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_is_empty,
  output logic signed [31:0] out_min_value,
  output logic signed [31:0] out_max_value,
  output logic [10:0]        out_entry_count,
  output logic               out_overflow
);

  dpq_cmd_t  cmd;
  dpq_stat_t stat;

  dpq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  dpq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_operation    (in_operation),
    .in_value        (in_value),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_is_empty    (out_is_empty),
    .out_min_value   (out_min_value),
    .out_max_value   (out_max_value),
    .out_entry_count (out_entry_count),
    .out_overflow    (out_overflow)
  );

endmodule
